// ===== hdl/mdfa_pkg.sv =====
// Shared types and constants for the multi-automaton pattern matcher.
package mdfa_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD_TRANS = 2'd0,
        ACT_LOAD_DESC  = 2'd1,
        ACT_LOAD_LIST  = 2'd2,
        ACT_BYTE       = 2'd3
    } t_action;

    typedef struct packed {
        t_action     action;
        logic [1:0]  dfa_sel;
        logic [9:0]  from_state;
        logic [7:0]  byte_value;
        logic [9:0]  target_state;
        logic [4:0]  out_count;
        logic [11:0] out_base;
        logic [11:0] list_index;
        logic [15:0] pattern_value;
        logic        first_byte;
        logic        last_byte;
    } t_in_item;

    typedef struct packed {
        logic        match_valid;
        logic [15:0] pattern_out;
        logic        end_of_packet;
        logic [12:0] packet_matches;
        logic        last_of_run;
    } t_out_item;

    // Output descriptor of one automaton state.
    typedef struct packed {
        logic [4:0]  count;
        logic [11:0] base;
    } t_desc;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRANS_RD,
        ST_DESC_RD,
        ST_DESC_WAIT,
        ST_DESC_TAKE,
        ST_REDUCE,
        ST_LIST_RD,
        ST_EMIT
    } t_seq_state;

    localparam logic [12:0] MATCH_MAX = 13'h1FFF;

endpackage

// ===== hdl/mdfa_tables.sv =====
// Transition, descriptor and pattern-list memories with registered reads.
module mdfa_tables
    import mdfa_pkg::*;
#(
    parameter int NUM_DFA        = 4,
    parameter int STATES_PER_DFA = 1024,
    parameter int MAX_OUT        = 16,
    parameter int LIST_DEPTH     = 4096,
    parameter int SLOT_W         = $clog2(NUM_DFA * STATES_PER_DFA),
    parameter int LA_W           = $clog2(LIST_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  t_in_item          i_wr_item,
    input  logic [SLOT_W+7:0] i_trans_raddr,
    input  logic [SLOT_W-1:0] i_desc_raddr,
    input  logic [LA_W-1:0]   i_list_raddr,
    output logic [9:0]        o_trans_rdata,
    output t_desc             o_desc_rdata,
    output logic [15:0]       o_list_rdata
);

    localparam int DESC_DEPTH  = NUM_DFA * STATES_PER_DFA;
    localparam int TRANS_DEPTH = DESC_DEPTH * 256;
    localparam logic [SLOT_W-1:0] STATES_C = SLOT_W'(STATES_PER_DFA);

    logic [9:0]  r_trans_mem [TRANS_DEPTH];
    t_desc       r_desc_mem  [DESC_DEPTH];
    logic [15:0] r_list_mem  [LIST_DEPTH];

    logic              w_slot_ok;
    logic              w_list_ok;
    logic [SLOT_W-1:0] w_slot;
    t_desc             w_desc;

    assign w_slot_ok = (5'(i_wr_item.dfa_sel) < 5'(NUM_DFA))
                    && (17'(i_wr_item.from_state) < 17'(STATES_PER_DFA));
    assign w_slot    = SLOT_W'(SLOT_W'(i_wr_item.dfa_sel) * STATES_C
                    + SLOT_W'(i_wr_item.from_state));
    assign w_list_ok = 17'(i_wr_item.list_index) < 17'(LIST_DEPTH);

    // A loaded count above the per-state limit is stored at the limit.
    assign w_desc.count = (7'(i_wr_item.out_count) > 7'(MAX_OUT))
                        ? 5'(MAX_OUT) : i_wr_item.out_count;
    assign w_desc.base  = i_wr_item.out_base;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && w_slot_ok && i_wr_item.action == ACT_LOAD_TRANS) begin
            r_trans_mem[{w_slot, i_wr_item.byte_value}] <= i_wr_item.target_state;
        end
        o_trans_rdata <= r_trans_mem[i_trans_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && w_slot_ok && i_wr_item.action == ACT_LOAD_DESC) begin
            r_desc_mem[w_slot] <= w_desc;
        end
        o_desc_rdata <= r_desc_mem[i_desc_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && w_list_ok && i_wr_item.action == ACT_LOAD_LIST) begin
            r_list_mem[LA_W'(i_wr_item.list_index)] <= i_wr_item.pattern_value;
        end
        o_list_rdata <= r_list_mem[i_list_raddr];
    end

endmodule

// ===== hdl/mdfa_ctrl.sv =====
// Sequencer that walks the automaton and emits match and end-of-packet items through one adder.
module mdfa_ctrl
    import mdfa_pkg::*;
#(
    parameter int NUM_DFA        = 4,
    parameter int STATES_PER_DFA = 1024,
    parameter int LIST_DEPTH     = 4096,
    parameter int SLOT_W         = $clog2(NUM_DFA * STATES_PER_DFA),
    parameter int LA_W           = $clog2(LIST_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  t_in_item          i_in_item,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output t_out_item         o_out_item,
    input  logic              i_out_ready,
    output logic [SLOT_W+7:0] o_trans_raddr,
    output logic [SLOT_W-1:0] o_desc_raddr,
    output logic [LA_W-1:0]   o_list_raddr,
    input  logic [9:0]        i_trans_rdata,
    input  t_desc             i_desc_rdata,
    input  logic [15:0]       i_list_rdata
);

    localparam logic [SLOT_W-1:0] STATES_C = SLOT_W'(STATES_PER_DFA);
    localparam logic [16:0]       LD_C     = 17'(LIST_DEPTH);
    localparam logic [16:0]       NEG_LD_C = 17'(~LD_C + 17'd1);

    t_seq_state  r_st, n_st;
    t_in_item    r_item, n_item;
    logic [9:0]  r_cur, n_cur;
    logic [12:0] r_cnt_m, n_cnt_m;
    logic [4:0]  r_cnt, n_cnt;
    logic [4:0]  r_i, n_i;
    logic [16:0] r_addr, n_addr;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic              w_accept;
    logic              w_out_free;
    logic              w_slot_ok;
    logic [SLOT_W-1:0] w_slot;
    logic [16:0]       w_alu_b;
    logic [16:0]       w_alu_sum;
    logic              w_need_reduce;
    logic              w_last_match;
    logic [12:0]       w_cnt_inc;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // One slot address serves both the transition and the descriptor read.
    assign w_slot_ok = (5'(r_item.dfa_sel) < 5'(NUM_DFA))
                    && (17'(r_cur) < 17'(STATES_PER_DFA));
    assign w_slot    = SLOT_W'(SLOT_W'(r_item.dfa_sel) * STATES_C + SLOT_W'(r_cur));

    assign o_trans_raddr = {w_slot, r_item.byte_value};
    assign o_desc_raddr  = w_slot;
    assign o_list_raddr  = r_addr[LA_W-1:0];

    // Shared adder: subtracts the list depth while reducing the base address,
    // and steps the list address by one while emitting.
    assign w_alu_b       = (r_st == ST_REDUCE) ? NEG_LD_C : 17'd1;
    assign w_alu_sum     = r_addr + w_alu_b;
    assign w_need_reduce = r_addr >= LD_C;

    assign w_last_match = (6'(r_i) + 6'd1) == 6'(r_cnt);
    assign w_cnt_inc    = (r_cnt_m != MATCH_MAX) ? r_cnt_m + 13'd1 : r_cnt_m;

    assign o_in_ready  = (r_st == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (w_accept && i_in_item.action == ACT_BYTE) begin
                    n_st = ST_TRANS_RD;
                end
            end
            ST_TRANS_RD:  n_st = ST_DESC_RD;
            ST_DESC_RD:   n_st = ST_DESC_WAIT;
            ST_DESC_WAIT: n_st = ST_DESC_TAKE;
            ST_DESC_TAKE: n_st = ST_REDUCE;
            ST_REDUCE: begin
                if (w_need_reduce) begin
                    n_st = ST_REDUCE;
                end else if (r_i < r_cnt) begin
                    n_st = ST_LIST_RD;
                end else if (r_item.last_byte) begin
                    n_st = ST_EMIT;
                end else begin
                    n_st = ST_IDLE;
                end
            end
            ST_LIST_RD: n_st = ST_EMIT;
            ST_EMIT: begin
                if (w_out_free) begin
                    if (r_i < r_cnt && !w_last_match) begin
                        n_st = ST_LIST_RD;
                    end else if (r_i < r_cnt && r_item.last_byte) begin
                        n_st = ST_EMIT;
                    end else begin
                        n_st = ST_IDLE;
                    end
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        n_item      = r_item;
        n_cur       = r_cur;
        n_cnt_m     = r_cnt_m;
        n_cnt       = r_cnt;
        n_i         = r_i;
        n_addr      = r_addr;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_st)
            ST_IDLE: begin
                if (w_accept && i_in_item.action == ACT_BYTE) begin
                    n_item = i_in_item;
                    if (i_in_item.first_byte) begin
                        n_cur   = '0;
                        n_cnt_m = '0;
                    end
                end
            end
            ST_DESC_RD: begin
                n_cur = w_slot_ok ? i_trans_rdata : 10'd0;
            end
            ST_DESC_TAKE: begin
                n_cnt  = w_slot_ok ? i_desc_rdata.count : 5'd0;
                n_addr = 17'(i_desc_rdata.base);
                n_i    = '0;
            end
            ST_REDUCE: begin
                if (w_need_reduce) begin
                    n_addr = w_alu_sum;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_i < r_cnt) begin
                        // A match item for the current list entry.
                        n_out.match_valid    = 1'b1;
                        n_out.pattern_out    = i_list_rdata;
                        n_out.end_of_packet  = 1'b0;
                        n_out.packet_matches = w_cnt_inc;
                        n_out.last_of_run    = w_last_match && !r_item.last_byte;
                        n_cnt_m              = w_cnt_inc;
                        n_i                  = 5'(r_i + 5'd1);
                        n_addr               = (w_alu_sum == LD_C) ? 17'd0 : w_alu_sum;
                    end else begin
                        // End-of-packet item, after which the walk restarts.
                        n_out.match_valid    = 1'b0;
                        n_out.pattern_out    = 16'd0;
                        n_out.end_of_packet  = 1'b1;
                        n_out.packet_matches = r_cnt_m;
                        n_out.last_of_run    = 1'b1;
                        n_cur                = '0;
                        n_cnt_m              = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_cur       <= '0;
            r_cnt_m     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_cur       <= n_cur;
            r_cnt_m     <= n_cnt_m;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_cnt  <= n_cnt;
        r_i    <= n_i;
        r_addr <= n_addr;
        r_out  <= n_out;
    end

endmodule

// ===== hdl/multi_dfa_pattern_matcher_unit.sv =====
// Load actions are written at their accepting edge and do not hold the input. A packet byte
// holds the input until its walk ends: transition read, descriptor read, wait and take, base
// reduction steps, a list read and an emit per match, an end item for a final byte, and any
// wait on the output. Time goes on the dependent transition, descriptor and list reads
// through registered ports, with one list-address adder. Reset (synchronous, active low)
// clears sequencer and automaton state, match count and output valid; memories are kept.
module multi_dfa_pattern_matcher_unit
    import mdfa_pkg::*;
#(
    parameter int NUM_DFA        = 4,
    parameter int STATES_PER_DFA = 1024,
    parameter int MAX_OUT        = 16,
    parameter int LIST_DEPTH     = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int SLOT_W = $clog2(NUM_DFA * STATES_PER_DFA);
    localparam int LA_W   = $clog2(LIST_DEPTH);

    logic [SLOT_W+7:0] w_trans_raddr;
    logic [SLOT_W-1:0] w_desc_raddr;
    logic [LA_W-1:0]   w_list_raddr;
    logic [9:0]        w_trans_rdata;
    t_desc             w_desc_rdata;
    logic [15:0]       w_list_rdata;

    mdfa_tables #(
        .NUM_DFA        (NUM_DFA),
        .STATES_PER_DFA (STATES_PER_DFA),
        .MAX_OUT        (MAX_OUT),
        .LIST_DEPTH     (LIST_DEPTH),
        .SLOT_W         (SLOT_W),
        .LA_W           (LA_W)
    ) u_tables (
        .i_clk         (i_clk),
        .i_wr_en       (i_in_valid && o_in_ready),
        .i_wr_item     (i_in_item),
        .i_trans_raddr (w_trans_raddr),
        .i_desc_raddr  (w_desc_raddr),
        .i_list_raddr  (w_list_raddr),
        .o_trans_rdata (w_trans_rdata),
        .o_desc_rdata  (w_desc_rdata),
        .o_list_rdata  (w_list_rdata)
    );

    mdfa_ctrl #(
        .NUM_DFA        (NUM_DFA),
        .STATES_PER_DFA (STATES_PER_DFA),
        .LIST_DEPTH     (LIST_DEPTH),
        .SLOT_W         (SLOT_W),
        .LA_W           (LA_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_item     (i_in_item),
        .o_in_ready    (o_in_ready),
        .o_out_valid   (o_out_valid),
        .o_out_item    (o_out_item),
        .i_out_ready   (i_out_ready),
        .o_trans_raddr (w_trans_raddr),
        .o_desc_raddr  (w_desc_raddr),
        .o_list_raddr  (w_list_raddr),
        .i_trans_rdata (w_trans_rdata),
        .i_desc_rdata  (w_desc_rdata),
        .i_list_rdata  (w_list_rdata)
    );

endmodule
